// ----- src/hid_key_report_tracker_unit_assert.svh -----
// assertion macros for the key report tracker
// needs nothing else; included by the files that carry concurrent assertions
`ifndef HID_KEY_REPORT_TRACKER_UNIT_ASSERT_SVH
`define HID_KEY_REPORT_TRACKER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define HKRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define HKRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HKRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define HKRT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- src/hkrt_pkg.sv -----
// shared types, constants and the ascii-to-usage table of the key report tracker
// no dependencies
`default_nettype none

package hkrt_pkg;

    // number of key slots held in the report
    localparam int KEY_SLOTS = 6;

    // slots shown on the result stream
    localparam int REPORT_SLOTS = 6;

    localparam int KEY_W      = 8;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = KEY_W * (REPORT_SLOTS + 1);

    // key code ranges
    localparam logic [7:0] RAW_BASE   = 8'd136;
    localparam logic [7:0] MOD_BASE   = 8'd128;
    localparam logic [7:0] LSHIFT_BIT = 8'h02;
    localparam logic [7:0] USAGE_MASK = 8'h7F;
    localparam logic [7:0] SHIFT_FLAG = 8'h80;

    // press or release
    typedef enum logic {
        CMD_PRESS   = 1'b0,
        CMD_RELEASE = 1'b1
    } key_cmd_t;

    // decoded key event
    typedef struct packed {
        logic             mapped;
        logic [KEY_W-1:0] usage;
        logic [KEY_W-1:0] mod_mask;
    } key_event_t;

    typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_slots_t;

    // ascii to usage, bit 7 asks for left shift, zero means unmapped
    localparam logic [7:0] ASCII_USAGE [128] = '{
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2a, 8'h2b, 8'h28, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h2c, 8'h9e, 8'hb4, 8'ha0, 8'ha1, 8'ha2, 8'ha4, 8'h34,
        8'ha6, 8'ha7, 8'ha5, 8'hae, 8'h36, 8'h2d, 8'h37, 8'h38,
        8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
        8'h25, 8'h26, 8'hb3, 8'h33, 8'hb6, 8'h2e, 8'hb7, 8'hb8,
        8'h9f, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89, 8'h8a,
        8'h8b, 8'h8c, 8'h8d, 8'h8e, 8'h8f, 8'h90, 8'h91, 8'h92,
        8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9a,
        8'h9b, 8'h9c, 8'h9d, 8'h2f, 8'h31, 8'h30, 8'ha3, 8'had,
        8'h35, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
        8'h0b, 8'h0c, 8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12,
        8'h13, 8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1a,
        8'h1b, 8'h1c, 8'h1d, 8'haf, 8'he4, 8'hb0, 8'hb2, 8'h00
    };

endpackage

`default_nettype wire

// ----- src/hkrt_decode.sv -----
// key code decoder: raw usage, modifier bit or ascii lookup
// depends on hkrt_pkg
`default_nettype none

module hkrt_decode
    import hkrt_pkg::*;
(
    input  wire logic [KEY_W-1:0] key_code,
    output key_event_t            key_event
);

    logic [7:0] table_entry;

    assign table_entry = ASCII_USAGE[key_code[6:0]];

    // classify the code and derive usage and modifier mask
    always_comb
    begin
        key_event.mapped   = 1'b1;
        key_event.usage    = '0;
        key_event.mod_mask = '0;
        if (key_code >= RAW_BASE)
        begin
            key_event.usage = key_code - RAW_BASE;
        end
        else if (key_code >= MOD_BASE)
        begin
            key_event.mod_mask = 8'h01 << key_code[2:0];
        end
        else if (table_entry == 8'h00)
        begin
            key_event.mapped = 1'b0;
        end
        else
        begin
            if ((table_entry & SHIFT_FLAG) != 8'h00)
            begin
                key_event.mod_mask = LSHIFT_BIT;
            end
            key_event.usage = table_entry & USAGE_MASK;
        end
    end

endmodule

`default_nettype wire

// ----- src/hkrt_report.sv -----
// report state: modifier byte and key slots, updated once per committed event
// depends on hkrt_pkg
`default_nettype none

module hkrt_report
    import hkrt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             commit,
    input  wire key_cmd_t         cmd,
    input  wire key_event_t       key_event,
    output logic                  accepted,
    output logic [KEY_W-1:0]      mods_cur,
    output key_slots_t            keys_cur,
    output logic [KEY_W-1:0]      mods_next,
    output key_slots_t            keys_next
);

    logic [KEY_W-1:0] mods_reg;
    key_slots_t       keys_reg;
    logic             present;
    logic             taken;
    key_slots_t       keys_press;
    key_slots_t       keys_release;

    // look for the usage and for the first empty slot
    always_comb
    begin
        present    = 1'b0;
        taken      = 1'b0;
        keys_press = keys_reg;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (keys_reg[i] == key_event.usage)
            begin
                present = 1'b1;
            end
        end
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (!taken && keys_reg[i] == '0)
            begin
                taken = 1'b1;
                if (!present)
                begin
                    keys_press[i] = key_event.usage;
                end
            end
        end
    end

    // clear every slot holding the event's usage, if that usage is nonzero
    always_comb
    begin
        keys_release = keys_reg;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (key_event.usage != '0 && keys_reg[i] == key_event.usage)
            begin
                keys_release[i] = '0;
            end
        end
    end

    // pick the report after this event
    always_comb
    begin
        accepted  = 1'b0;
        mods_next = mods_reg;
        keys_next = keys_reg;
        if (key_event.mapped)
        begin
            case (cmd)
                CMD_PRESS:
                begin
                    mods_next = mods_reg | key_event.mod_mask;
                    keys_next = keys_press;
                    accepted  = present || taken;
                end
                CMD_RELEASE:
                begin
                    mods_next = mods_reg & ~key_event.mod_mask;
                    keys_next = keys_release;
                    accepted  = 1'b1;
                end
                default:
                begin
                    accepted = 1'b0;
                end
            endcase
        end
    end

    // report registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= '0;
            keys_reg <= '0;
        end
        else if (commit)
        begin
            mods_reg <= mods_next;
            keys_reg <= keys_next;
        end
    end

    assign mods_cur = mods_reg;
    assign keys_cur = keys_reg;

endmodule

`default_nettype wire

// ----- src/hid_key_report_tracker_unit.sv -----
// keyboard report tracker top level: input register, decoder, report, result register
// depends on hkrt_pkg, hkrt_decode, hkrt_report and the assertion macro header
//
// Usage:
// - s_axis carries one key event per transfer: tuser is the command (press or
//   release), tdata the key code (ascii, modifier code or raw usage plus 136).
// - m_axis returns one result per event: tuser is the accepted flag, tdata the
//   whole report after the event (modifier byte then six key slots).
// - an event is registered on input, then decoded and applied to the report
//   as it moves into the result register, from which the result is taken.
// - throughput is one event per cycle while the receiver keeps up; the report
//   update is a single pass of slot compares and a first-empty search between
//   the input and result registers.
// - when the receiver stalls, the result register holds and one more event is
//   taken into the input register; then s_axis_tready drops until the result
//   is taken.
// - reset empties both registers and clears the report (no modifiers, all
//   slots empty).
`default_nettype none

`include "hid_key_report_tracker_unit_assert.svh"

module hid_key_report_tracker_unit
    import hkrt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // key_code
    input  wire logic                  s_axis_tuser,   // cmd
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // modifier_bits, slot_zero .. slot_five
    output logic                       m_axis_tuser    // accepted
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    key_cmd_t               in_cmd_reg;
    logic [KEY_W-1:0]       in_code_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;
    logic                   out_acc_reg;
    logic                   advance;
    logic                   commit;
    logic                   s_xfer;
    logic                   m_xfer;
    key_event_t             key_event;
    logic                   accepted;
    logic [KEY_W-1:0]       mods_cur;
    key_slots_t             keys_cur;
    logic [KEY_W-1:0]       mods_next;
    key_slots_t             keys_next;

    // handshake control
    assign advance       = !out_valid_reg || m_axis_tready;
    assign commit        = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign m_xfer        = out_valid_reg && m_axis_tready;

    assign in_valid_next  = s_xfer ? 1'b1 : (commit ? 1'b0 : in_valid_reg);
    assign out_valid_next = commit ? 1'b1 : (m_xfer ? 1'b0 : out_valid_reg);

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input payload
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_cmd_reg  <= key_cmd_t'(s_axis_tuser);
            in_code_reg <= s_axis_tdata;
        end
    end

    hkrt_decode u_decode (
        .key_code  (in_code_reg),
        .key_event (key_event)
    );

    hkrt_report u_report (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .cmd       (in_cmd_reg),
        .key_event (key_event),
        .accepted  (accepted),
        .mods_cur  (mods_cur),
        .keys_cur  (keys_cur),
        .mods_next (mods_next),
        .keys_next (keys_next)
    );

    // pack the report, slots beyond the held count read empty
    assign out_data_next[KEY_W-1:0] = mods_next;
    for (genvar j = 0; j < REPORT_SLOTS; j++)
    begin : g_slot
        if (j < KEY_SLOTS)
        begin : g_held
            assign out_data_next[KEY_W*(j+2)-1 -: KEY_W] = keys_next[j];
        end
        else
        begin : g_empty
            assign out_data_next[KEY_W*(j+2)-1 -: KEY_W] = '0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            out_data_reg <= out_data_next;
            out_acc_reg  <= accepted;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_acc_reg;

    // checks
    `HKRT_ASSERT_NXT(a_in_held, clk, rst_n, in_valid_reg && !advance, in_valid_reg,
        "pending key event dropped while result stalled")
    `HKRT_ASSERT_IMP(a_no_overrun, clk, rst_n, in_valid_reg && out_valid_reg && !m_axis_tready,
        !s_axis_tready, "input taken while both stages are full")
    `HKRT_ASSERT_IMP(a_unmapped_keeps, clk, rst_n, commit && !key_event.mapped,
        !accepted && mods_next == mods_cur && keys_next == keys_cur,
        "unmapped key changed the report")
    `HKRT_ASSERT_NXT(a_result_follows, clk, rst_n, commit,
        out_valid_reg && out_acc_reg == $past(accepted),
        "committed event did not reach the result register")

endmodule

`default_nettype wire
